// ----- rtl/core/gsd_pkg.sv -----
// Package for the GIF stream deframer: parse phases, byte kinds, field ids,
// error codes and the per-item result record.
// Depends on nothing; used by gsd_parser and gif_stream_deframer.
`default_nettype none

package gsd_pkg;

  // Parse phases of the block walker
  typedef enum logic [3:0] {
    PH_SIG,
    PH_VER,
    PH_SCREEN,
    PH_GPAL,
    PH_INTRO,
    PH_LABEL,
    PH_GCE,
    PH_SUBLEN,
    PH_PAYLOAD,
    PH_IMGDESC,
    PH_LPAL,
    PH_MINCODE,
    PH_IDLE
  } phase_e;

  // Byte kinds
  localparam logic [3:0] KIND_HEADER  = 4'd0;
  localparam logic [3:0] KIND_SCREEN  = 4'd1;
  localparam logic [3:0] KIND_GPAL    = 4'd2;
  localparam logic [3:0] KIND_INTRO   = 4'd3;
  localparam logic [3:0] KIND_LABEL   = 4'd4;
  localparam logic [3:0] KIND_GCE     = 4'd5;
  localparam logic [3:0] KIND_SUBLEN  = 4'd6;
  localparam logic [3:0] KIND_PAYLOAD = 4'd7;
  localparam logic [3:0] KIND_IMGDESC = 4'd8;
  localparam logic [3:0] KIND_LPAL    = 4'd9;
  localparam logic [3:0] KIND_MINCODE = 4'd10;
  localparam logic [3:0] KIND_TRAILER = 4'd11;
  localparam logic [3:0] KIND_IGNORED = 4'd12;

  // Field ids
  localparam logic [4:0] FID_NONE       = 5'd0;
  localparam logic [4:0] FID_VERSION    = 5'd1;
  localparam logic [4:0] FID_CANVAS_W   = 5'd2;
  localparam logic [4:0] FID_CANVAS_H   = 5'd3;
  localparam logic [4:0] FID_SCR_PACKED = 5'd4;
  localparam logic [4:0] FID_BG_INDEX   = 5'd5;
  localparam logic [4:0] FID_ASPECT     = 5'd6;
  localparam logic [4:0] FID_GCE_SIZE   = 5'd7;
  localparam logic [4:0] FID_GCE_PACKED = 5'd8;
  localparam logic [4:0] FID_GCE_DELAY  = 5'd9;
  localparam logic [4:0] FID_TRANSP_IDX = 5'd10;
  localparam logic [4:0] FID_IMG_LEFT   = 5'd11;
  localparam logic [4:0] FID_IMG_PACKED = 5'd15;
  localparam logic [4:0] FID_MIN_CODE   = 5'd16;
  localparam logic [4:0] FID_EXT_LABEL  = 5'd17;

  // Latched error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_SIG       = 2'd1;
  localparam logic [1:0] ERR_VERSION   = 2'd2;
  localparam logic [1:0] ERR_INTRO     = 2'd3;

  // Stream bytes
  localparam logic [7:0] CH_G         = 8'h47;
  localparam logic [7:0] CH_I         = 8'h49;
  localparam logic [7:0] CH_F         = 8'h46;
  localparam logic [7:0] CH_8         = 8'h38;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_7         = 8'h37;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] INTRO_EXT    = 8'd33;
  localparam logic [7:0] INTRO_IMAGE  = 8'd44;
  localparam logic [7:0] INTRO_TRAIL  = 8'd59;
  localparam logic [7:0] LABEL_GCE    = 8'd249;

  // Version values reported in the version field
  localparam logic [15:0] VER_87 = 16'd87;
  localparam logic [15:0] VER_89 = 16'd89;

  // Palette channel codes
  localparam logic [1:0] CHAN_RED  = 2'd0;
  localparam logic [1:0] CHAN_BLUE = 2'd2;

  // One result item
  typedef struct packed {
    logic [3:0]  byte_kind;
    logic [7:0]  data_out;
    logic [7:0]  palette_index;
    logic [1:0]  color_channel;
    logic [4:0]  field_id;
    logic [15:0] field_value;
    logic        is_version_89a;
    logic [1:0]  error_code;
    logic        gce_terminator_bad;
    logic        stream_done;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/gsd_parser.sv -----
// Parse state registers and the one-byte step of the GIF block walker.
// Depends on gsd_pkg for phases, codes and the result record.
`default_nettype none

module gsd_parser
  import gsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output result_t         result_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  pidx_q, pidx_d;
  logic [1:0]  chan_q, chan_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  rem_q, rem_d;
  logic [2:0]  tsize_q, tsize_d;
  logic        tpres_q, tpres_d;
  logic        ver89_q, ver89_d;
  logic [1:0]  err_q, err_d;
  logic        done_q, done_d;

  logic [8:0]  pal_entries;
  logic [7:0]  pal_last;
  logic        pal_end;
  logic [7:0]  rem_dec;
  logic [7:0]  sig_char;

  // Last palette entry index for the current size code
  assign pal_entries = 9'd2 << tsize_q;
  assign pal_last    = pal_entries[7:0] - 8'd1;
  assign pal_end     = (chan_q == CHAN_BLUE) && (pidx_q == pal_last);
  assign rem_dec     = rem_q - 8'd1;

  // Expected signature byte
  always_comb begin
    case (pos_q)
      4'd0:    sig_char = CH_G;
      4'd1:    sig_char = CH_I;
      default: sig_char = CH_F;
    endcase
  end

  // One step of the walker
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q + 4'd1;
    pidx_d  = pidx_q;
    chan_d  = chan_q;
    low_d   = low_q;
    rem_d   = rem_q;
    tsize_d = tsize_q;
    tpres_d = tpres_q;
    ver89_d = ver89_q;
    err_d   = err_q;
    done_d  = done_q;

    result_o = '0;
    result_o.byte_kind = KIND_IGNORED;
    result_o.data_out  = byte_i;

    case (phase_q)
      PH_SIG: begin
        result_o.byte_kind = KIND_HEADER;
        if (pos_q > 4'd2 || byte_i != sig_char) begin
          err_d   = ERR_SIG;
          phase_d = PH_IDLE;
          pos_d   = '0;
        end else if (pos_q == 4'd2) begin
          phase_d = PH_VER;
          pos_d   = '0;
        end
      end
      PH_VER: begin
        result_o.byte_kind = KIND_HEADER;
        if (pos_q == 4'd0 && byte_i == CH_8) begin
          // first version digit ok
        end else if (pos_q == 4'd1 && (byte_i == CH_9 || byte_i == CH_7)) begin
          ver89_d = (byte_i == CH_9);
        end else if (pos_q == 4'd2 && byte_i == CH_A) begin
          result_o.field_id    = FID_VERSION;
          result_o.field_value = ver89_q ? VER_89 : VER_87;
          phase_d = PH_SCREEN;
          pos_d   = '0;
        end else begin
          err_d   = ERR_VERSION;
          phase_d = PH_IDLE;
          pos_d   = '0;
        end
      end
      PH_SCREEN: begin
        result_o.byte_kind = KIND_SCREEN;
        case (pos_q)
          4'd0, 4'd2: low_d = byte_i;
          4'd1: begin
            result_o.field_id    = FID_CANVAS_W;
            result_o.field_value = {byte_i, low_q};
          end
          4'd3: begin
            result_o.field_id    = FID_CANVAS_H;
            result_o.field_value = {byte_i, low_q};
          end
          4'd4: begin
            result_o.field_id    = FID_SCR_PACKED;
            result_o.field_value = {8'd0, byte_i};
            tpres_d = byte_i[7];
            tsize_d = byte_i[2:0];
          end
          4'd5: begin
            result_o.field_id    = FID_BG_INDEX;
            result_o.field_value = {8'd0, byte_i};
          end
          default: begin
            result_o.field_id    = FID_ASPECT;
            result_o.field_value = {8'd0, byte_i};
            pos_d   = '0;
            phase_d = tpres_q ? PH_GPAL : PH_INTRO;
          end
        endcase
      end
      PH_GPAL, PH_LPAL: begin
        result_o.byte_kind     = (phase_q == PH_GPAL) ? KIND_GPAL : KIND_LPAL;
        result_o.palette_index = pidx_q;
        result_o.color_channel = chan_q;
        pos_d = '0;
        if (chan_q == CHAN_BLUE) begin
          chan_d = CHAN_RED;
          pidx_d = pidx_q + 8'd1;
        end else begin
          chan_d = chan_q + 2'd1;
        end
        if (pal_end) begin
          chan_d  = CHAN_RED;
          pidx_d  = '0;
          phase_d = (phase_q == PH_GPAL) ? PH_INTRO : PH_MINCODE;
        end
      end
      PH_INTRO: begin
        pos_d = '0;
        if (byte_i == INTRO_EXT) begin
          result_o.byte_kind = KIND_INTRO;
          phase_d = PH_LABEL;
        end else if (byte_i == INTRO_IMAGE) begin
          result_o.byte_kind = KIND_INTRO;
          phase_d = PH_IMGDESC;
        end else if (byte_i == INTRO_TRAIL) begin
          result_o.byte_kind = KIND_TRAILER;
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          result_o.byte_kind = KIND_INTRO;
          err_d   = ERR_INTRO;
          phase_d = PH_IDLE;
        end
      end
      PH_LABEL: begin
        result_o.byte_kind   = KIND_LABEL;
        result_o.field_id    = FID_EXT_LABEL;
        result_o.field_value = {8'd0, byte_i};
        pos_d   = '0;
        phase_d = (byte_i == LABEL_GCE) ? PH_GCE : PH_SUBLEN;
      end
      PH_GCE: begin
        result_o.byte_kind = KIND_GCE;
        case (pos_q)
          4'd0: begin
            result_o.field_id    = FID_GCE_SIZE;
            result_o.field_value = {8'd0, byte_i};
          end
          4'd1: begin
            result_o.field_id    = FID_GCE_PACKED;
            result_o.field_value = {8'd0, byte_i};
          end
          4'd2: low_d = byte_i;
          4'd3: begin
            result_o.field_id    = FID_GCE_DELAY;
            result_o.field_value = {byte_i, low_q};
          end
          4'd4: begin
            result_o.field_id    = FID_TRANSP_IDX;
            result_o.field_value = {8'd0, byte_i};
          end
          default: begin
            // block terminator
            result_o.gce_terminator_bad = (byte_i != 8'd0);
            pos_d   = '0;
            phase_d = PH_INTRO;
          end
        endcase
      end
      PH_SUBLEN: begin
        result_o.byte_kind = KIND_SUBLEN;
        pos_d = '0;
        if (byte_i == 8'd0) begin
          phase_d = PH_INTRO;
        end else begin
          rem_d   = byte_i;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        result_o.byte_kind = KIND_PAYLOAD;
        pos_d = '0;
        rem_d = rem_dec;
        if (rem_dec == 8'd0) phase_d = PH_SUBLEN;
      end
      PH_IMGDESC: begin
        result_o.byte_kind = KIND_IMGDESC;
        if (pos_q < 4'd8) begin
          if (!pos_q[0]) begin
            low_d = byte_i;
          end else begin
            result_o.field_id    = FID_IMG_LEFT + {3'd0, pos_q[2:1]};
            result_o.field_value = {byte_i, low_q};
          end
        end else begin
          result_o.field_id    = FID_IMG_PACKED;
          result_o.field_value = {8'd0, byte_i};
          pos_d   = '0;
          tpres_d = byte_i[7];
          tsize_d = byte_i[2:0];
          phase_d = byte_i[7] ? PH_LPAL : PH_MINCODE;
        end
      end
      PH_MINCODE: begin
        result_o.byte_kind   = KIND_MINCODE;
        result_o.field_id    = FID_MIN_CODE;
        result_o.field_value = {8'd0, byte_i};
        pos_d   = '0;
        phase_d = PH_SUBLEN;
      end
      default: begin
        result_o.byte_kind = KIND_IGNORED;
        pos_d = '0;
      end
    endcase

    // Status fields show the state after this item
    result_o.is_version_89a = ver89_d;
    result_o.error_code     = err_d;
    result_o.stream_done    = done_d;
  end

  // State registers, updated when an item moves to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      pos_q   <= '0;
      pidx_q  <= '0;
      chan_q  <= CHAN_RED;
      low_q   <= '0;
      rem_q   <= '0;
      tsize_q <= '0;
      tpres_q <= 1'b0;
      ver89_q <= 1'b0;
      err_q   <= ERR_NONE;
      done_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      pidx_q  <= pidx_d;
      chan_q  <= chan_d;
      low_q   <= low_d;
      rem_q   <= rem_d;
      tsize_q <= tsize_d;
      tpres_q <= tpres_d;
      ver89_q <= ver89_d;
      err_q   <= err_d;
      done_q  <= done_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gif_stream_deframer.sv -----
// Top level of the GIF stream deframer: input register, parser, result register.
// Depends on gsd_pkg and gsd_parser.
`default_nettype none

// GIF87a/89a block parser. Takes one file byte per item and gives one result
// per byte: its kind, the byte itself, palette entry and channel for palette
// bytes, and any header field that the byte completes. Sustains one item per
// clock unless the output stalls; an item passes the input register, then the
// result register, with the one-byte parser step between them. The input side
// stalls only when both the input register and the result register hold items
// and the output is stalled. After a bad signature, bad version, unknown
// introducer or the trailer, every further byte reports as ignored.
module gif_stream_deframer
  import gsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       byte_kind_o,
  output logic [7:0]       data_out_o,
  output logic [7:0]       palette_index_o,
  output logic [1:0]       color_channel_o,
  output logic [4:0]       field_id_o,
  output logic [15:0]      field_value_o,
  output logic             is_version_89a_o,
  output logic [1:0]       error_code_o,
  output logic             gce_terminator_bad_o,
  output logic             stream_done_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       res_vld_q;
  result_t    res_q;
  result_t    res_d;
  logic       res_free;
  logic       step;
  logic       in_take;

  // Handshake: result stage frees when empty or taken
  assign res_free   = !res_vld_q || !out_stall_i;
  assign step       = in_vld_q && res_free;
  assign in_stall_o = in_vld_q && !res_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
    end
  end

  gsd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = res_vld_q;
  assign byte_kind_o          = res_q.byte_kind;
  assign data_out_o           = res_q.data_out;
  assign palette_index_o      = res_q.palette_index;
  assign color_channel_o      = res_q.color_channel;
  assign field_id_o           = res_q.field_id;
  assign field_value_o        = res_q.field_value;
  assign is_version_89a_o     = res_q.is_version_89a;
  assign error_code_o         = res_q.error_code;
  assign gce_terminator_bad_o = res_q.gce_terminator_bad;
  assign stream_done_o        = res_q.stream_done;

endmodule

`default_nettype wire
